>>> rtl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

	localparam int RRTS_NUM_TASKS = 16;
	localparam int RRTS_LOCK_BITS = 8;
	localparam int IDLE_TASK      = 0;

	localparam int MODE_W = 3;
	localparam int TIME_W = 64;
	localparam int TASK_W = 4;

	typedef enum logic [MODE_W-1:0] {
		MD_TICK    = 3'd0,
		MD_SLEEP   = 3'd1,
		MD_BLOCK   = 3'd2,
		MD_UNBLOCK = 3'd3,
		MD_CREATE  = 3'd4,
		MD_LOCK    = 3'd5,
		MD_UNLOCK  = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		SS_ABSENT   = 3'd0,
		SS_READY    = 3'd1,
		SS_RUNNING  = 3'd2,
		SS_SLEEPING = 3'd3,
		SS_WAITING  = 3'd4
	} slot_state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOCK_INC,
		DP_LOCK_DEC,
		DP_SLEEP,
		DP_BLOCK,
		DP_SWEEP,
		DP_SCAN_INIT,
		DP_SCAN,
		DP_RD_ACTIVE,
		DP_RELEASE,
		DP_COMMIT,
		DP_RD_IDX,
		DP_UNBLOCK,
		DP_CREATE
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SWEEP,
		S_SCAN_INIT,
		S_SCAN,
		S_RD_ACTIVE,
		S_RELEASE,
		S_COMMIT,
		S_RD_IDX,
		S_UPD_IDX,
		S_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} rrts_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  lock_nz;
		logic  idx_ok;
		logic  sweep_done;
		logic  scan_done;
		logic  pick_avail;
	} rrts_sts_t;

endpackage

`default_nettype wire

>>> rtl/round_robin_task_scheduler_unit.sv
// Channel   Ports                                        Handshake
// request   mode, now_ns, deadline_ns, task_index        start high while busy low
// result    active_task, switched, switch_locked         done high for one cycle
//
// One request is processed at a time; busy stays high from acceptance through
// the cycle in which done is high. A tick sweeps the slots and, like sleep and
// block, then scans them unless switching is locked; the one-read-per-cycle port
// of the slot state memory makes each sweep or scan visit one slot per cycle.
// Reset clears all control state at once; no memory clearing pass is needed.
// Results cannot be stalled, so done is never held off.
`default_nettype none

module round_robin_task_scheduler_unit
	import rrts_pkg::*;
#(
	parameter int NUM_TASKS = RRTS_NUM_TASKS,
	parameter int LOCK_BITS = RRTS_LOCK_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [TIME_W-1:0] now_ns,
	input  wire logic [TIME_W-1:0] deadline_ns,
	input  wire logic [TASK_W-1:0] task_index,
	output logic                   done,
	output logic      [TASK_W-1:0] active_task,
	output logic                   switched,
	output logic                   switch_locked
);

	rrts_cmd_t cmd;
	rrts_sts_t sts;

	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	rrts_datapath #(
		.NUM_TASKS (NUM_TASKS),
		.LOCK_BITS (LOCK_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.now_ns        (now_ns),
		.deadline_ns   (deadline_ns),
		.task_index    (task_index),
		.active_task   (active_task),
		.switched      (switched),
		.switch_locked (switch_locked)
	);

endmodule

`default_nettype wire

>>> rtl/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl
	import rrts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	output logic           done,
	output rrts_cmd_t      cmd,
	input  wire rrts_sts_t sts
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.mode)
					MD_TICK: begin
						state_d = S_SWEEP;
					end
					MD_SLEEP, MD_BLOCK: begin
						state_d = sts.lock_nz ? S_RESULT : S_SCAN_INIT;
					end
					MD_UNBLOCK, MD_CREATE: begin
						state_d = sts.idx_ok ? S_RD_IDX : S_RESULT;
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_SWEEP: begin
				if (sts.sweep_done) begin
					state_d = sts.lock_nz ? S_RESULT : S_SCAN_INIT;
				end
			end
			S_SCAN_INIT: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_RD_ACTIVE;
				end
			end
			S_RD_ACTIVE: begin
				state_d = sts.pick_avail ? S_RELEASE : S_RESULT;
			end
			S_RELEASE: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_RESULT;
			end
			S_RD_IDX: begin
				state_d = S_UPD_IDX;
			end
			S_UPD_IDX: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.capture = 1'b0;
		cmd.op      = DP_NONE;
		busy        = 1'b1;
		done        = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			S_DISPATCH: begin
				case (sts.mode)
					MD_SLEEP: begin
						cmd.op = DP_SLEEP;
					end
					MD_BLOCK: begin
						cmd.op = DP_BLOCK;
					end
					MD_LOCK: begin
						cmd.op = DP_LOCK_INC;
					end
					MD_UNLOCK: begin
						cmd.op = DP_LOCK_DEC;
					end
					default: begin
						cmd.op = DP_NONE;
					end
				endcase
			end
			S_SWEEP: begin
				cmd.op = DP_SWEEP;
			end
			S_SCAN_INIT: begin
				cmd.op = DP_SCAN_INIT;
			end
			S_SCAN: begin
				cmd.op = DP_SCAN;
			end
			S_RD_ACTIVE: begin
				cmd.op = DP_RD_ACTIVE;
			end
			S_RELEASE: begin
				cmd.op = DP_RELEASE;
			end
			S_COMMIT: begin
				cmd.op = DP_COMMIT;
			end
			S_RD_IDX: begin
				cmd.op = DP_RD_IDX;
			end
			S_UPD_IDX: begin
				cmd.op = (sts.mode == MD_UNBLOCK) ? DP_UNBLOCK : DP_CREATE;
			end
			S_RESULT: begin
				done = 1'b1;
			end
			default: begin
				cmd.op = DP_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/rrts_datapath.sv
`default_nettype none

module rrts_datapath
	import rrts_pkg::*;
#(
	parameter int NUM_TASKS = RRTS_NUM_TASKS,
	parameter int LOCK_BITS = RRTS_LOCK_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rrts_cmd_t         cmd,
	output rrts_sts_t              sts,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [TIME_W-1:0] now_ns,
	input  wire logic [TIME_W-1:0] deadline_ns,
	input  wire logic [TASK_W-1:0] task_index,
	output logic      [TASK_W-1:0] active_task,
	output logic                   switched,
	output logic                   switch_locked
);

	localparam int SLOT_W = $clog2(NUM_TASKS);
	localparam int CNT_W  = $clog2(NUM_TASKS + 1);
	localparam int WIDE_W = SLOT_W + TASK_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TASKS - 1);
	localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(IDLE_TASK);
	localparam logic [CNT_W-1:0]  SWEEP_END = CNT_W'(NUM_TASKS);
	localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(NUM_TASKS - 1);

	function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	// Slot state and wake time stores. A slot whose valid bit is clear reads as
	// its reset state. Wake times are only read for sleeping slots, and a slot
	// only sleeps after its wake time was written, so that store has no valid bits.
	slot_state_t             st_mem [NUM_TASKS];
	logic [TIME_W-1:0]       wk_mem [NUM_TASKS];
	logic [NUM_TASKS-1:0]    vld_q;

	mode_t                   mode_q;
	logic [TIME_W-1:0]       time_q;
	logic [TASK_W-1:0]       idx_q;
	logic [SLOT_W-1:0]       active_q;
	logic [LOCK_BITS-1:0]    lock_q;
	logic                    switched_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SLOT_W-1:0]       ptr_q;
	logic                    found_q;
	logic                    idle_rdy_q;
	logic [SLOT_W-1:0]       pick_q;

	slot_state_t             st_mem_s1;
	logic                    st_vld_s1;
	logic [TIME_W-1:0]       wk_s1;
	logic [SLOT_W-1:0]       addr_s1;
	logic                    sweep_s1;
	logic                    scan_s1;

	logic [SLOT_W-1:0]       rd_addr;
	slot_state_t             st_s1;
	logic [WIDE_W-1:0]       idx_wide;
	logic [SLOT_W-1:0]       idx_slot;
	logic [WIDE_W-1:0]       act_wide;
	logic [SLOT_W-1:0]       pick_slot;

	logic                    st_we;
	logic [SLOT_W-1:0]       st_waddr;
	slot_state_t             st_wdata;
	logic                    wk_we;
	logic [TIME_W-1:0]       wk_wdata;

	assign idx_wide  = WIDE_W'(idx_q);
	assign idx_slot  = idx_wide[SLOT_W-1:0];
	assign pick_slot = found_q ? pick_q : IDLE_SLOT;

	always_comb begin
		case (cmd.op)
			DP_SWEEP:   rd_addr = cnt_q[SLOT_W-1:0];
			DP_SCAN:    rd_addr = ptr_q;
			DP_RD_IDX:  rd_addr = idx_slot;
			default:    rd_addr = active_q;
		endcase
	end

	always_ff @(posedge clk) begin
		st_mem_s1 <= st_mem[rd_addr];
		wk_s1     <= wk_mem[rd_addr];
		addr_s1   <= rd_addr;
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (wk_we) begin
			wk_mem[st_waddr] <= wk_wdata;
		end
	end

	always_comb begin
		if (st_vld_s1) begin
			st_s1 = st_mem_s1;
		end else begin
			st_s1 = (addr_s1 == IDLE_SLOT) ? SS_RUNNING : SS_ABSENT;
		end
	end

	always_comb begin
		st_we    = 1'b0;
		st_waddr = active_q;
		st_wdata = SS_READY;
		wk_we    = 1'b0;
		wk_wdata = time_q;
		case (cmd.op)
			DP_SLEEP: begin
				st_we    = 1'b1;
				st_wdata = SS_SLEEPING;
				wk_we    = 1'b1;
			end
			DP_BLOCK: begin
				st_we    = 1'b1;
				st_wdata = SS_WAITING;
			end
			DP_SWEEP: begin
				st_waddr = addr_s1;
				st_we    = sweep_s1 && (addr_s1 != active_q) &&
					(st_s1 == SS_SLEEPING) && (time_q >= wk_s1);
			end
			DP_RELEASE: begin
				st_we = (st_s1 == SS_RUNNING);
			end
			DP_COMMIT: begin
				st_we    = 1'b1;
				st_waddr = pick_slot;
				st_wdata = SS_RUNNING;
			end
			DP_UNBLOCK: begin
				st_waddr = idx_slot;
				st_we    = (st_s1 != SS_ABSENT) && (st_s1 != SS_RUNNING);
				st_wdata = (idx_slot == active_q) ? SS_RUNNING : SS_READY;
			end
			DP_CREATE: begin
				st_waddr = idx_slot;
				st_we    = (st_s1 == SS_ABSENT);
				wk_we    = (st_s1 == SS_ABSENT);
				wk_wdata = '0;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			time_q <= (mode_t'(mode) == MD_TICK) ? now_ns : deadline_ns;
			idx_q  <= task_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			active_q   <= IDLE_SLOT;
			lock_q     <= '0;
			switched_q <= 1'b0;
			cnt_q      <= '0;
			ptr_q      <= '0;
			found_q    <= 1'b0;
			idle_rdy_q <= 1'b0;
			pick_q     <= '0;
			st_vld_s1  <= 1'b0;
			sweep_s1   <= 1'b0;
			scan_s1    <= 1'b0;
		end else begin
			st_vld_s1 <= vld_q[rd_addr];
			sweep_s1  <= (cmd.op == DP_SWEEP) && (cnt_q != SWEEP_END);
			scan_s1   <= (cmd.op == DP_SCAN) && (cnt_q != SCAN_END);
			if (st_we) begin
				vld_q[st_waddr] <= 1'b1;
			end
			if (cmd.capture) begin
				switched_q <= 1'b0;
				cnt_q      <= '0;
			end
			// The scan keeps the idle slot as a fallback: any other ready slot wins.
			if (scan_s1 && (st_s1 == SS_READY)) begin
				if (addr_s1 == IDLE_SLOT) begin
					idle_rdy_q <= 1'b1;
				end else if (!found_q) begin
					found_q <= 1'b1;
					pick_q  <= addr_s1;
				end
			end
			case (cmd.op)
				DP_LOCK_INC: begin
					if (lock_q != '1) begin
						lock_q <= lock_q + 1'b1;
					end
				end
				DP_LOCK_DEC: begin
					if (lock_q != '0) begin
						lock_q <= lock_q - 1'b1;
					end
				end
				DP_SWEEP: begin
					if (cnt_q != SWEEP_END) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DP_SCAN_INIT: begin
					cnt_q      <= '0;
					ptr_q      <= ring_next(active_q);
					found_q    <= 1'b0;
					idle_rdy_q <= 1'b0;
				end
				DP_SCAN: begin
					if (cnt_q != SCAN_END) begin
						cnt_q <= cnt_q + 1'b1;
						ptr_q <= ring_next(ptr_q);
					end
				end
				DP_COMMIT: begin
					active_q   <= pick_slot;
					switched_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.mode       = mode_q;
	assign sts.lock_nz    = (lock_q != '0);
	assign sts.idx_ok     = (32'(idx_q) < NUM_TASKS);
	assign sts.sweep_done = (cnt_q == SWEEP_END);
	assign sts.scan_done  = (cnt_q == SCAN_END);
	assign sts.pick_avail = found_q | idle_rdy_q;

	assign act_wide      = WIDE_W'(active_q);
	assign active_task   = act_wide[TASK_W-1:0];
	assign switched      = switched_q;
	assign switch_locked = (lock_q != '0);

endmodule

`default_nettype wire

>>> rtl/rrts_checker.sv
`default_nettype none

module rrts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// A result only appears while a request is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// Every request ends with exactly one result just before busy drops.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
